[src/heightfield_vertex_normal_shader_unit_macros.svh]
// Assertion macros for the heightfield vertex normal shader.
// Taken in by the files that carry concurrent checks; no other dependencies.
`ifndef HEIGHTFIELD_VERTEX_NORMAL_SHADER_UNIT_MACROS_SVH
`define HEIGHTFIELD_VERTEX_NORMAL_SHADER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// plain implication check, clocked on rising edge, disabled in reset
`define HVN_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// condition in one cycle implies a condition in the next
`define HVN_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define HVN_ASSERT(lbl, clk, rst_n, prop, msg)
`define HVN_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif

`endif

[src/hvn_pkg.sv]
// Shared types, constants and helpers of the heightfield vertex normal shader.
// No dependencies.
package hvn_pkg;

  // grid limits (defaults of the top level parameters)
  localparam int MAX_COLUMNS = 256;
  localparam int MAX_ROWS    = 4096;

  // field widths
  localparam int HEIGHT_W  = 32;
  localparam int IDX_W     = 20;
  localparam int NRM_W     = 16;
  localparam int SHADE_W   = 15;
  localparam int LIGHT_W   = 16;
  localparam int SPACING_W = 31;

  // width of a vector entering the normalizer, and of the face normal sum
  localparam int V_W   = 34;
  localparam int ACC_W = 18;

  localparam int Q14_ONE     = 16384;
  localparam int SHADE_FLOOR = 1638;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLUMNS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_SPACING = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_X      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_Y      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_Z      = 3'd5;

  localparam logic [8:0]           RST_GRID_COLUMNS = 9'd2;
  localparam logic [12:0]          RST_GRID_ROWS    = 13'd2;
  localparam logic [SPACING_W-1:0] RST_CELL_SPACING = 31'd65536;
  localparam logic [LIGHT_W-1:0]   RST_LIGHT_X      = 16'h0000;
  localparam logic [LIGHT_W-1:0]   RST_LIGHT_Y      = 16'hC000;
  localparam logic [LIGHT_W-1:0]   RST_LIGHT_Z      = 16'h0000;

  // request to the shared normalizer
  typedef struct packed {
    logic                  start;
    logic signed [V_W-1:0] x;
    logic signed [V_W-1:0] y;
    logic signed [V_W-1:0] z;
  } hvn_norm_req_t;

  // status and result of the shared normalizer
  typedef struct packed {
    logic                    busy;
    logic                    done;
    logic signed [NRM_W-1:0] nx;
    logic signed [NRM_W-1:0] ny;
    logic signed [NRM_W-1:0] nz;
  } hvn_norm_rsp_t;

  // line store slot arithmetic, modulo three
  function automatic logic [1:0] inc3(input logic [1:0] s);
    return (s == 2'd2) ? 2'd0 : s + 2'd1;
  endfunction

  function automatic logic [1:0] dec3(input logic [1:0] s);
    return (s == 2'd0) ? 2'd2 : s - 2'd1;
  endfunction

  // height difference, widened so that it cannot overflow
  function automatic logic signed [V_W-1:0] hdiff(input logic signed [HEIGHT_W-1:0] a,
                                                  input logic signed [HEIGHT_W-1:0] b);
    return V_W'(a) - V_W'(b);
  endfunction

endpackage

[src/hvn_if.sv]
// Valid/ready stream interfaces for heights in and shaded vertices out.
// Depends on hvn_pkg for the field widths.
interface hvn_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [hvn_pkg::HEIGHT_W-1:0]  height;

  modport source (output valid, output height, input ready);
  modport sink   (input valid, input height, output ready);
endinterface

interface hvn_out_if;
  logic                                 valid;
  logic                                 ready;
  logic        [hvn_pkg::IDX_W-1:0]     vertex_index;
  logic signed [hvn_pkg::NRM_W-1:0]     normal_x;
  logic signed [hvn_pkg::NRM_W-1:0]     normal_y;
  logic signed [hvn_pkg::NRM_W-1:0]     normal_z;
  logic        [hvn_pkg::SHADE_W-1:0]   shade;
  logic                                 last;

  modport source (output valid, output vertex_index, output normal_x, output normal_y,
                  output normal_z, output shade, output last, input ready);
  modport sink   (input valid, input vertex_index, input normal_x, input normal_y,
                  input normal_z, input shade, input last, output ready);
endinterface

[src/hvn_ram.sv]
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module hvn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 768
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[src/hvn_norm.sv]
// Shared vector normalizer: scales a 3-vector to a Q1.14 unit vector.
// Bit-per-cycle scaling, three squares, digit-serial square root, then
// restoring division per component. Depends on hvn_pkg.
module hvn_norm (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  hvn_pkg::hvn_norm_req_t req_i,
  output hvn_pkg::hvn_norm_rsp_t rsp_o
);

  localparam int MW = hvn_pkg::V_W;

  localparam logic [2:0] N_IDLE  = 3'd0;
  localparam logic [2:0] N_SHIFT = 3'd1;
  localparam logic [2:0] N_SQ    = 3'd2;
  localparam logic [2:0] N_SQRT  = 3'd3;
  localparam logic [2:0] N_DSET  = 3'd4;
  localparam logic [2:0] N_DIV   = 3'd5;
  localparam logic [2:0] N_DONE  = 3'd6;

  logic [2:0]     st_q;
  logic [MW-1:0]  m0_q, m1_q, m2_q;
  logic [2:0]     neg_q;
  logic [4:0]     cnt_q;
  logic [1:0]     k_q;
  logic [47:0]    prod_q;
  logic [49:0]    s_q;
  logic [49:0]    rv_q;
  logic [49:0]    r_q;
  logic [24:0]    len_q;
  logic [24:0]    rem_q;
  logic [14:0]    lo_q;
  logic [14:0]    q_q;
  logic signed [hvn_pkg::NRM_W-1:0] n0_q, n1_q, n2_q;

  // magnitudes of the request
  logic [MW-1:0] mx, my, mz;
  assign mx = req_i.x[MW-1] ? MW'(-req_i.x) : MW'(req_i.x);
  assign my = req_i.y[MW-1] ? MW'(-req_i.y) : MW'(req_i.y);
  assign mz = req_i.z[MW-1] ? MW'(-req_i.z) : MW'(req_i.z);

  logic [MW-1:0] orv;
  assign orv = m0_q | m1_q | m2_q;

  // component picked by k for squares and division
  logic [23:0] msel;
  always_comb begin
    case (k_q)
      2'd0:    msel = m0_q[23:0];
      2'd1:    msel = m1_q[23:0];
      default: msel = m2_q[23:0];
    endcase
  end

  // one square root digit
  logic [49:0] bitv;
  logic [50:0] sq_t;
  logic        sq_take;
  logic [49:0] r_nx;
  assign bitv    = 50'd1 << {cnt_q, 1'b0};
  assign sq_t    = {1'b0, r_q} + {1'b0, bitv};
  assign sq_take = ({1'b0, rv_q} >= sq_t);
  assign r_nx    = sq_take ? ((r_q >> 1) + bitv) : (r_q >> 1);

  // division setup and one quotient bit
  logic [38:0] num;
  logic [25:0] dv_t;
  logic        dv_take;
  logic [14:0] q_nx;
  logic signed [hvn_pkg::NRM_W-1:0] q_sgn;
  assign num     = {1'b0, msel, 14'd0} + 39'(len_q >> 1);
  assign dv_t    = {rem_q, lo_q[14]};
  assign dv_take = (dv_t >= {1'b0, len_q});
  assign q_nx    = {q_q[13:0], dv_take};
  assign q_sgn   = neg_q[k_q] ? -$signed({1'b0, q_nx}) : $signed({1'b0, q_nx});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= N_IDLE;
      m0_q   <= '0;
      m1_q   <= '0;
      m2_q   <= '0;
      neg_q  <= '0;
      cnt_q  <= '0;
      k_q    <= '0;
      prod_q <= '0;
      s_q    <= '0;
      rv_q   <= '0;
      r_q    <= '0;
      len_q  <= '0;
      rem_q  <= '0;
      lo_q   <= '0;
      q_q    <= '0;
      n0_q   <= '0;
      n1_q   <= '0;
      n2_q   <= '0;
    end else begin
      case (st_q)
        N_IDLE: begin
          if (req_i.start) begin
            m0_q  <= mx;
            m1_q  <= my;
            m2_q  <= mz;
            neg_q <= {req_i.z[MW-1], req_i.y[MW-1], req_i.x[MW-1]};
            if ((mx | my | mz) == '0) begin
              n0_q <= '0;
              n1_q <= '0;
              n2_q <= '0;
              st_q <= N_DONE;
            end else begin
              st_q <= N_SHIFT;
            end
          end
        end
        // bring the largest magnitude into [2^23, 2^24)
        N_SHIFT: begin
          if (|orv[MW-1:24]) begin
            m0_q <= m0_q >> 1;
            m1_q <= m1_q >> 1;
            m2_q <= m2_q >> 1;
          end else if (!orv[23]) begin
            m0_q <= m0_q << 1;
            m1_q <= m1_q << 1;
            m2_q <= m2_q << 1;
          end else begin
            k_q  <= 2'd0;
            s_q  <= '0;
            st_q <= N_SQ;
          end
        end
        // multiply, then add the product in the next cycle
        N_SQ: begin
          prod_q <= msel * msel;
          if (k_q != 2'd0) begin
            s_q <= s_q + 50'(prod_q);
          end
          if (k_q == 2'd3) begin
            rv_q  <= s_q + 50'(prod_q);
            r_q   <= '0;
            cnt_q <= 5'd24;
            st_q  <= N_SQRT;
          end else begin
            k_q <= k_q + 2'd1;
          end
        end
        N_SQRT: begin
          if (sq_take) begin
            rv_q <= rv_q - sq_t[49:0];
          end
          r_q <= r_nx;
          if (cnt_q == 5'd0) begin
            len_q <= r_nx[24:0];
            k_q   <= 2'd0;
            st_q  <= N_DSET;
          end else begin
            cnt_q <= cnt_q - 5'd1;
          end
        end
        // rounded numerator; the top part is already below the length
        N_DSET: begin
          rem_q <= {1'b0, num[38:15]};
          lo_q  <= num[14:0];
          q_q   <= '0;
          cnt_q <= 5'd14;
          st_q  <= N_DIV;
        end
        N_DIV: begin
          rem_q <= dv_take ? 25'(dv_t - {1'b0, len_q}) : dv_t[24:0];
          lo_q  <= lo_q << 1;
          q_q   <= q_nx;
          if (cnt_q == 5'd0) begin
            case (k_q)
              2'd0:    n0_q <= q_sgn;
              2'd1:    n1_q <= q_sgn;
              default: n2_q <= q_sgn;
            endcase
            if (k_q == 2'd2) begin
              st_q <= N_DONE;
            end else begin
              k_q  <= k_q + 2'd1;
              st_q <= N_DSET;
            end
          end else begin
            cnt_q <= cnt_q - 5'd1;
          end
        end
        N_DONE: begin
          st_q <= N_IDLE;
        end
        default: begin
          st_q <= N_IDLE;
        end
      endcase
    end
  end

  assign rsp_o.busy = (st_q != N_IDLE);
  assign rsp_o.done = (st_q == N_DONE);
  assign rsp_o.nx   = n0_q;
  assign rsp_o.ny   = n1_q;
  assign rsp_o.nz   = n2_q;

endmodule

[src/heightfield_vertex_normal_shader_unit.sv]
// Each finished vertex of an item goes through selection and store reads, up to seven passes through
// the shared normalizer (shift, square root and division steps; a face that does not exist is skipped,
// a zero vector goes straight to done) and shading; an item that finishes no vertex returns to idle.
// Throughput: one item at a time; the input waits until the item's vertices are produced.
// Reset: configuration to defaults, counters zero; the line store is not cleared.
module heightfield_vertex_normal_shader_unit #(
  parameter int MAX_COLUMNS = hvn_pkg::MAX_COLUMNS,
  parameter int MAX_ROWS    = hvn_pkg::MAX_ROWS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [hvn_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [hvn_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  hvn_in_if.sink                          in_i,
  hvn_out_if.source                       out_o
);

`include "heightfield_vertex_normal_shader_unit_macros.svh"

  localparam int COL_W = $clog2(MAX_COLUMNS);
  localparam int ROW_W = $clog2(MAX_ROWS);
  localparam int DEPTH = 3 * MAX_COLUMNS;
  localparam int AW    = $clog2(DEPTH);
  localparam int IW    = ROW_W + COL_W + 1;
  localparam int HW    = hvn_pkg::HEIGHT_W;
  localparam int VW    = hvn_pkg::V_W;
  localparam int AC    = hvn_pkg::ACC_W;
  localparam logic [AW-1:0] MC_A = AW'(MAX_COLUMNS);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_EMIT  = 4'd1;
  localparam logic [3:0] S_READ  = 4'd2;
  localparam logic [3:0] S_FACE  = 4'd3;
  localparam logic [3:0] S_FWAIT = 4'd4;
  localparam logic [3:0] S_VEC   = 4'd5;
  localparam logic [3:0] S_VWAIT = 4'd6;
  localparam logic [3:0] S_SHADE = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  // configuration registers
  logic [8:0]                      cols_cfg_q;
  logic [12:0]                     rows_cfg_q;
  logic [hvn_pkg::SPACING_W-1:0]   spacing_q;
  logic signed [hvn_pkg::LIGHT_W-1:0] lx_q, ly_q, lz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_cfg_q <= hvn_pkg::RST_GRID_COLUMNS;
      rows_cfg_q <= hvn_pkg::RST_GRID_ROWS;
      spacing_q  <= hvn_pkg::RST_CELL_SPACING;
      lx_q       <= hvn_pkg::RST_LIGHT_X;
      ly_q       <= hvn_pkg::RST_LIGHT_Y;
      lz_q       <= hvn_pkg::RST_LIGHT_Z;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        hvn_pkg::CFG_GRID_COLUMNS: cols_cfg_q <= cfg_data_i[8:0];
        hvn_pkg::CFG_GRID_ROWS:    rows_cfg_q <= cfg_data_i[12:0];
        hvn_pkg::CFG_CELL_SPACING: spacing_q  <= cfg_data_i;
        hvn_pkg::CFG_LIGHT_X:      lx_q       <= cfg_data_i[15:0];
        hvn_pkg::CFG_LIGHT_Y:      ly_q       <= cfg_data_i[15:0];
        hvn_pkg::CFG_LIGHT_Z:      lz_q       <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // effective grid size, saturated to the supported range
  logic [31:0]    gc32, gr32, ce32, re32;
  logic [COL_W:0] cols;
  logic [ROW_W:0] rows;
  assign gc32 = 32'(cols_cfg_q);
  assign gr32 = 32'(rows_cfg_q);
  assign ce32 = (gc32 < 32'd2) ? 32'd2 :
                (gc32 > 32'(MAX_COLUMNS)) ? 32'(MAX_COLUMNS) : gc32;
  assign re32 = (gr32 < 32'd2) ? 32'd2 :
                (gr32 > 32'(MAX_ROWS)) ? 32'(MAX_ROWS) : gr32;
  assign cols = ce32[COL_W:0];
  assign rows = re32[ROW_W:0];

  function automatic logic [AW-1:0] st_addr(input logic [1:0] slot,
                                            input logic [COL_W-1:0] col);
    return AW'(slot) * MC_A + AW'(col);
  endfunction

  logic [3:0]       st_q;
  logic [ROW_W-1:0] row_q, rk_q, er_q;
  logic [COL_W-1:0] col_q, ck_q, ec_q;
  logic [1:0]       rm_q, rmk_q, es_q;
  logic [3:0]       e_q;
  logic [2:0]       a_q;
  logic [2:0]       f_q;
  logic [1:0]       k_q;
  logic signed [HW-1:0] h_q [7];
  logic signed [AC-1:0] ax_q, ay_q, az_q;
  logic signed [hvn_pkg::NRM_W-1:0] nx_q, ny_q, nz_q;
  logic signed [31:0] prod_q;
  logic signed [33:0] dacc_q;

  // output register
  logic                            ov_q;
  logic [hvn_pkg::IDX_W-1:0]       o_idx_q;
  logic signed [hvn_pkg::NRM_W-1:0] o_nx_q, o_ny_q, o_nz_q;
  logic [hvn_pkg::SHADE_W-1:0]     o_sh_q;
  logic                            o_last_q;

  // input transfer: position of the item and the vertices it finishes
  logic             in_xfer;
  logic             beyond;
  logic [ROW_W-1:0] rc;
  logic [COL_W-1:0] cc;
  logic [1:0]       rmc;
  logic             c_last, r_last;
  assign in_i.ready = (st_q == S_IDLE);
  assign in_xfer    = in_i.valid && in_i.ready;
  assign beyond     = ({1'b0, row_q} >= rows) || ({1'b0, col_q} >= cols);
  assign rc         = beyond ? '0 : row_q;
  assign cc         = beyond ? '0 : col_q;
  assign rmc        = beyond ? 2'd0 : rm_q;
  assign c_last     = (({1'b0, cc} + 1'b1) == cols);
  assign r_last     = (({1'b0, rc} + 1'b1) == rows);

  // line store
  logic [AW-1:0] raddr;
  logic [HW-1:0] rdata;
  always_comb begin
    case (a_q)
      3'd0:    raddr = st_addr(es_q, ec_q);
      3'd1:    raddr = st_addr(es_q, ec_q - 1'b1);
      3'd2:    raddr = st_addr(es_q, ec_q + 1'b1);
      3'd3:    raddr = st_addr(hvn_pkg::dec3(es_q), ec_q);
      3'd4:    raddr = st_addr(hvn_pkg::inc3(es_q), ec_q);
      3'd5:    raddr = st_addr(hvn_pkg::inc3(es_q), ec_q - 1'b1);
      default: raddr = st_addr(hvn_pkg::dec3(es_q), ec_q + 1'b1);
    endcase
  end

  hvn_ram #(
    .WIDTH (HW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (in_xfer),
    .waddr_i (st_addr(rmc, cc)),
    .wdata_i (in_i.height),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // neighbors of the vertex: center, left, right, up, down, down-left, up-right
  logic signed [HW-1:0] hc, hl, hr, hu, hd, hdl, hur;
  assign hc  = h_q[0];
  assign hl  = h_q[1];
  assign hr  = h_q[2];
  assign hu  = h_q[3];
  assign hd  = h_q[4];
  assign hdl = h_q[5];
  assign hur = h_q[6];

  // which adjacent faces exist
  logic have_dn, have_up, have_rt, have_lf, sp_ok, face_ok;
  assign have_dn = (({1'b0, er_q} + 1'b1) < rows);
  assign have_up = (er_q != '0);
  assign have_rt = (({1'b0, ec_q} + 1'b1) < cols);
  assign have_lf = (ec_q != '0);
  assign sp_ok   = (spacing_q != '0);

  logic signed [VW-1:0] fx, fz;
  always_comb begin
    case (f_q)
      3'd0: begin
        face_ok = have_dn && have_rt;
        fx = hvn_pkg::hdiff(hc, hr);
        fz = hvn_pkg::hdiff(hd, hc);
      end
      3'd1: begin
        face_ok = have_dn && have_lf;
        fx = hvn_pkg::hdiff(hl, hc);
        fz = hvn_pkg::hdiff(hdl, hl);
      end
      3'd2: begin
        face_ok = have_dn && have_lf;
        fx = hvn_pkg::hdiff(hdl, hd);
        fz = hvn_pkg::hdiff(hd, hc);
      end
      3'd3: begin
        face_ok = have_up && have_rt;
        fx = hvn_pkg::hdiff(hu, hur);
        fz = hvn_pkg::hdiff(hc, hu);
      end
      3'd4: begin
        face_ok = have_up && have_rt;
        fx = hvn_pkg::hdiff(hc, hr);
        fz = hvn_pkg::hdiff(hr, hur);
      end
      default: begin
        face_ok = have_up && have_lf;
        fx = hvn_pkg::hdiff(hl, hc);
        fz = hvn_pkg::hdiff(hc, hu);
      end
    endcase
    face_ok = face_ok && sp_ok;
  end

  // shared normalizer
  hvn_pkg::hvn_norm_req_t req;
  hvn_pkg::hvn_norm_rsp_t rsp;
  always_comb begin
    req.start = 1'b0;
    req.x     = fx;
    req.y     = VW'(spacing_q);
    req.z     = fz;
    if (st_q == S_FACE) begin
      req.start = face_ok;
    end else if (st_q == S_VEC) begin
      req.start = 1'b1;
      req.x     = VW'(ax_q);
      req.y     = VW'(ay_q);
      req.z     = VW'(az_q);
    end
  end

  hvn_norm u_norm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  // shading operands
  logic signed [hvn_pkg::LIGHT_W-1:0] lsel;
  logic signed [hvn_pkg::NRM_W-1:0]   nsel;
  always_comb begin
    case (k_q)
      2'd0:    begin lsel = lx_q; nsel = nx_q; end
      2'd1:    begin lsel = ly_q; nsel = ny_q; end
      default: begin lsel = lz_q; nsel = nz_q; end
    endcase
  end

  logic signed [33:0] dv, dr;
  logic [14:0]        shade;
  assign dv = -dacc_q;
  assign dr = (dv + 34'sd8192) >>> 14;
  always_comb begin
    if (dv <= 34'sd0 || dr < 34'(hvn_pkg::SHADE_FLOOR)) begin
      shade = 15'(hvn_pkg::SHADE_FLOOR);
    end else if (dr > 34'(hvn_pkg::Q14_ONE)) begin
      shade = 15'(hvn_pkg::Q14_ONE);
    end else begin
      shade = dr[14:0];
    end
  end

  logic [IW-1:0] vfull;
  logic          vlast;
  logic          out_free;
  assign vfull    = IW'(er_q) * IW'(cols) + IW'(ec_q);
  assign vlast    = (({1'b0, er_q} + 1'b1) == rows) && (({1'b0, ec_q} + 1'b1) == cols);
  assign out_free = !ov_q || out_o.ready;

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_IDLE;
      row_q  <= '0;
      col_q  <= '0;
      rm_q   <= 2'd0;
      rk_q   <= '0;
      ck_q   <= '0;
      rmk_q  <= 2'd0;
      er_q   <= '0;
      ec_q   <= '0;
      es_q   <= 2'd0;
      e_q    <= '0;
      a_q    <= '0;
      f_q    <= '0;
      k_q    <= '0;
      ax_q   <= '0;
      ay_q   <= '0;
      az_q   <= '0;
      nx_q   <= '0;
      ny_q   <= '0;
      nz_q   <= '0;
      prod_q <= '0;
      dacc_q <= '0;
      for (int i = 0; i < 7; i++) begin
        h_q[i] <= '0;
      end
    end else begin
      case (st_q)
        S_IDLE: begin
          if (in_xfer) begin
            rk_q  <= rc;
            ck_q  <= cc;
            rmk_q <= rmc;
            e_q[0] <= (rc != '0) && (cc != '0);
            e_q[1] <= (rc != '0) && (cc != '0) && c_last;
            e_q[2] <= r_last && (cc != '0);
            e_q[3] <= r_last && (cc != '0) && c_last;
            // advance the grid position
            if (c_last) begin
              col_q <= '0;
              if (r_last) begin
                row_q <= '0;
                rm_q  <= 2'd0;
              end else begin
                row_q <= rc + 1'b1;
                rm_q  <= hvn_pkg::inc3(rmc);
              end
            end else begin
              col_q <= cc + 1'b1;
              row_q <= rc;
              rm_q  <= rmc;
            end
            st_q <= S_EMIT;
          end
        end
        // pick the next finished vertex in output order
        S_EMIT: begin
          a_q  <= '0;
          ax_q <= '0;
          ay_q <= '0;
          az_q <= '0;
          st_q <= S_READ;
          if (e_q[0]) begin
            e_q[0] <= 1'b0;
            er_q <= rk_q - 1'b1;
            ec_q <= ck_q - 1'b1;
            es_q <= hvn_pkg::dec3(rmk_q);
          end else if (e_q[1]) begin
            e_q[1] <= 1'b0;
            er_q <= rk_q - 1'b1;
            ec_q <= ck_q;
            es_q <= hvn_pkg::dec3(rmk_q);
          end else if (e_q[2]) begin
            e_q[2] <= 1'b0;
            er_q <= rk_q;
            ec_q <= ck_q - 1'b1;
            es_q <= rmk_q;
          end else if (e_q[3]) begin
            e_q[3] <= 1'b0;
            er_q <= rk_q;
            ec_q <= ck_q;
            es_q <= rmk_q;
          end else begin
            st_q <= S_IDLE;
          end
        end
        // seven reads, data lands in the cycle after its address
        S_READ: begin
          if (a_q != 3'd0) begin
            h_q[a_q - 3'd1] <= rdata;
          end
          if (a_q == 3'd7) begin
            f_q  <= '0;
            st_q <= S_FACE;
          end else begin
            a_q <= a_q + 3'd1;
          end
        end
        S_FACE: begin
          if (face_ok) begin
            st_q <= S_FWAIT;
          end else if (f_q == 3'd5) begin
            st_q <= S_VEC;
          end else begin
            f_q <= f_q + 3'd1;
          end
        end
        S_FWAIT: begin
          if (rsp.done) begin
            ax_q <= ax_q + AC'(rsp.nx);
            ay_q <= ay_q + AC'(rsp.ny);
            az_q <= az_q + AC'(rsp.nz);
            if (f_q == 3'd5) begin
              st_q <= S_VEC;
            end else begin
              f_q  <= f_q + 3'd1;
              st_q <= S_FACE;
            end
          end
        end
        S_VEC: begin
          st_q <= S_VWAIT;
        end
        S_VWAIT: begin
          if (rsp.done) begin
            nx_q   <= rsp.nx;
            ny_q   <= rsp.ny;
            nz_q   <= rsp.nz;
            k_q    <= '0;
            dacc_q <= '0;
            st_q   <= S_SHADE;
          end
        end
        // dot product with the light: multiply, then accumulate
        S_SHADE: begin
          prod_q <= lsel * nsel;
          if (k_q != 2'd0) begin
            dacc_q <= dacc_q + 34'(prod_q);
          end
          if (k_q == 2'd3) begin
            st_q <= S_OUT;
          end else begin
            k_q <= k_q + 2'd1;
          end
        end
        S_OUT: begin
          if (out_free) begin
            st_q <= S_EMIT;
          end
        end
        default: begin
          st_q <= S_IDLE;
        end
      endcase
    end
  end

  // output register, refilled as soon as the held result is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q     <= 1'b0;
      o_idx_q  <= '0;
      o_nx_q   <= '0;
      o_ny_q   <= '0;
      o_nz_q   <= '0;
      o_sh_q   <= '0;
      o_last_q <= 1'b0;
    end else if (st_q == S_OUT && out_free) begin
      ov_q     <= 1'b1;
      o_idx_q  <= hvn_pkg::IDX_W'(vfull);
      o_nx_q   <= nx_q;
      o_ny_q   <= ny_q;
      o_nz_q   <= nz_q;
      o_sh_q   <= shade;
      o_last_q <= vlast;
    end else if (out_o.ready) begin
      ov_q <= 1'b0;
    end
  end

  assign out_o.valid        = ov_q;
  assign out_o.vertex_index = o_idx_q;
  assign out_o.normal_x     = o_nx_q;
  assign out_o.normal_y     = o_ny_q;
  assign out_o.normal_z     = o_nz_q;
  assign out_o.shade        = o_sh_q;
  assign out_o.last         = o_last_q;

  // checks
  `HVN_ASSERT(a_norm_idle, clk_i, rst_ni, req.start |-> !rsp.busy, "normalizer started while busy")
  `HVN_ASSERT_NEXT(a_one_item, clk_i, rst_ni, in_xfer, !in_i.ready, "second item taken while busy")
  `HVN_ASSERT(a_unit_x, clk_i, rst_ni, out_o.valid |-> (o_nx_q <= 16384 && o_nx_q >= -16384), "normal out of range")
  `HVN_ASSERT(a_shade, clk_i, rst_ni, out_o.valid |-> (o_sh_q >= 15'd1638 && o_sh_q <= 15'd16384), "shade out of range")

endmodule
